// File: rtl/vlpd_pkg.sv
// Shared types and constants of the varint length-prefixed deframer.
`timescale 1ns / 1ps

package vlpd_pkg;

    localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;
    localparam logic [7:0] PREAMBLE_BYTE    = 8'h00;
    localparam logic [15:0] BUF_LIMIT_RESET = 16'd128;

    localparam logic [2:0] K_HEADER  = 3'd0;
    localparam logic [2:0] K_PAYLOAD = 3'd1;
    localparam logic [2:0] K_EMPTY   = 3'd2;
    localparam logic [2:0] K_SKIP    = 3'd3;
    localparam logic [2:0] K_ERROR   = 3'd4;
    localparam logic [2:0] K_HALTED  = 3'd5;

    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_TYPE     = 3'd2,
        PH_MESSAGE  = 3'd3,
        PH_SKIP     = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] byte_position;
        logic [31:0] varint_value;
        logic [2:0]  varint_count;
        logic [31:0] length;
        logic [31:0] msg_type;
        logic        halted;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] msg_type;
        logic [31:0] message_length;
        logic        last;
    } result_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:         PH_PREAMBLE,
        byte_position: 32'd0,
        varint_value:  32'd0,
        varint_count:  3'd0,
        length:        32'd0,
        msg_type:      32'd0,
        halted:        1'b0
    };

endpackage

// File: rtl/vlpd_step.sv
// Per-item parser step: next parse state and result for one stream byte.
`timescale 1ns / 1ps

module vlpd_step (
    input  vlpd_pkg::parse_state_t state,
    input  logic [15:0]            buf_limit,
    input  logic [7:0]             data_byte,
    output vlpd_pkg::parse_state_t state_next,
    output vlpd_pkg::result_t      result
);

    logic [6:0]  low7;
    logic [31:0] shifted;
    logic [31:0] acc_value;
    logic [2:0]  count_inc;
    logic        vi_over;
    logic        vi_done;
    logic [31:0] pos_inc;
    logic [2:0]  kind;
    logic [7:0]  pay;
    logic        last;

    assign low7      = data_byte[6:0];
    assign acc_value = state.varint_value | shifted;
    assign count_inc = state.varint_count + 3'd1;
    assign pos_inc   = state.byte_position + 32'd1;

    always_comb begin
        case (state.varint_count)
            3'd0:    shifted = {25'd0, low7};
            3'd1:    shifted = {18'd0, low7, 7'd0};
            3'd2:    shifted = {11'd0, low7, 14'd0};
            3'd3:    shifted = {4'd0, low7, 21'd0};
            3'd4:    shifted = {low7[3:0], 28'd0};
            default: shifted = 32'd0;
        endcase
    end

    always_comb begin
        vi_over = 1'b0;
        vi_done = 1'b0;
        if (state.varint_count >= vlpd_pkg::VARINT_MAX_BYTES) begin
            vi_over = 1'b1;
        end else if (!data_byte[7]) begin
            vi_done = 1'b1;
        end else if (count_inc >= vlpd_pkg::VARINT_MAX_BYTES) begin
            vi_over = 1'b1;
        end
    end

    always_comb begin
        state_next = state;
        kind = vlpd_pkg::K_HEADER;
        pay  = 8'd0;
        last = 1'b0;
        if (state.halted) begin
            kind = vlpd_pkg::K_HALTED;
        end else begin
            unique case (state.phase)
                vlpd_pkg::PH_LENGTH, vlpd_pkg::PH_TYPE: begin
                    if (vi_over) begin
                        kind = vlpd_pkg::K_ERROR;
                        state_next.halted = 1'b1;
                        if (state.varint_count < vlpd_pkg::VARINT_MAX_BYTES) begin
                            state_next.varint_value = acc_value;
                            state_next.varint_count = count_inc;
                        end
                    end else if (vi_done) begin
                        if (state.phase == vlpd_pkg::PH_LENGTH) begin
                            state_next.length = acc_value;
                            state_next.phase  = vlpd_pkg::PH_TYPE;
                        end else begin
                            state_next.msg_type      = acc_value;
                            state_next.byte_position = 32'd0;
                            if (state.length == 32'd0) begin
                                kind = vlpd_pkg::K_EMPTY;
                                last = 1'b1;
                                state_next.phase = vlpd_pkg::PH_PREAMBLE;
                            end else if (state.length >= {16'd0, buf_limit}) begin
                                state_next.phase = vlpd_pkg::PH_SKIP;
                            end else begin
                                state_next.phase = vlpd_pkg::PH_MESSAGE;
                            end
                        end
                        state_next.varint_value = 32'd0;
                        state_next.varint_count = 3'd0;
                    end else begin
                        state_next.varint_value = acc_value;
                        state_next.varint_count = count_inc;
                    end
                end
                vlpd_pkg::PH_MESSAGE, vlpd_pkg::PH_SKIP: begin
                    if (state.phase == vlpd_pkg::PH_MESSAGE) begin
                        kind = vlpd_pkg::K_PAYLOAD;
                        pay  = data_byte;
                    end else begin
                        kind = vlpd_pkg::K_SKIP;
                    end
                    state_next.byte_position = pos_inc;
                    if (pos_inc == state.length) begin
                        last = 1'b1;
                        state_next.byte_position = 32'd0;
                        state_next.phase = vlpd_pkg::PH_PREAMBLE;
                    end
                end
                default: begin
                    if (data_byte != vlpd_pkg::PREAMBLE_BYTE) begin
                        kind = vlpd_pkg::K_ERROR;
                        state_next.halted = 1'b1;
                    end else begin
                        state_next.phase         = vlpd_pkg::PH_LENGTH;
                        state_next.varint_value  = 32'd0;
                        state_next.varint_count  = 3'd0;
                        state_next.byte_position = 32'd0;
                    end
                end
            endcase
        end
    end

    assign result = '{
        kind:           kind,
        payload_byte:   pay,
        msg_type:       state_next.msg_type,
        message_length: state_next.length,
        last:           last
    };

endmodule

// File: rtl/varint_length_prefixed_deframer_core.sv
// Top level of the varint length-prefixed deframer: registers and handshakes.
//
//  Group  | Dir | Handshake              | Payload
//  s_     | in  | s_tvalid / s_tready    | tdata[7:0] data_byte
//  m_     | out | m_tvalid / m_tready    | tdata payload/type/length, tuser kind, tlast last
//  cfg_   | in  | cfg_valid / cfg_ready  | cfg_data[15:0] buffer limit
//
// One byte per cycle sustained while m_tready keeps up; a byte passes the input register,
// then one step of parser logic into the result register.
// Reset clears the parser state, both valid flags and sets the buffer limit to 128.
// A stalled result holds the result register; the input register takes a byte
// while it is empty, or while its byte moves into a free or draining result register.
`timescale 1ns / 1ps

module varint_length_prefixed_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] payload_byte, [39:8] msg_type,
                                   // [71:40] message_length
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] buffer limit
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    vlpd_pkg::result_t      out_reg;
    vlpd_pkg::parse_state_t state_reg;
    vlpd_pkg::parse_state_t state_next;
    vlpd_pkg::result_t      res_next;
    logic [15:0]            buf_limit_reg;
    logic                   advance;
    logic                   s_accept;

    vlpd_step u_step (
        .state       (state_reg),
        .buf_limit   (buf_limit_reg),
        .data_byte   (in_byte_reg),
        .state_next  (state_next),
        .result      (res_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= vlpd_pkg::PARSE_STATE_RESET;
            buf_limit_reg   <= vlpd_pkg::BUF_LIMIT_RESET;
        end else begin
            if (cfg_valid) begin
                buf_limit_reg <= cfg_data;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.message_length, out_reg.msg_type, out_reg.payload_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

// File: rtl/vlpd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps

module vlpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    logic m_accept;
    assign m_accept = m_tvalid && m_tready;

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && (m_tuser == vlpd_pkg::K_ERROR)
        |=> !m_tvalid || (m_tuser == vlpd_pkg::K_HALTED))
        else $error("item after an error not marked halted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != vlpd_pkg::K_PAYLOAD) |-> (m_tdata[7:0] == 8'd0))
        else $error("payload byte nonzero outside payload item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == vlpd_pkg::K_PAYLOAD)
            || (m_tuser == vlpd_pkg::K_EMPTY) || (m_tuser == vlpd_pkg::K_SKIP))
        else $error("last set on a header, error or halted item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind varint_length_prefixed_deframer_core vlpd_checker u_vlpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/tb_varint_length_prefixed_deframer_core.sv
// Testbench for the varint length-prefixed deframer core: byte streams against a predictor.
`timescale 1ns / 1ps

module tb_varint_length_prefixed_deframer_core;

    import vlpd_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_SIZE = 270;

    typedef enum int {
        HALT_BAD_PREAMBLE,
        HALT_LONG_LENGTH,
        HALT_LONG_TYPE
    } halt_cause_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;             // [7:0] payload_byte, [39:8] msg_type,
                                      // [71:40] message_length
    logic [2:0]  m_tuser;             // [2:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000; // [15:0] buffer limit

    // predictor state
    phase_t      rx_phase = PH_PREAMBLE;
    logic [31:0] rx_pos = '0;
    logic [31:0] rx_acc = '0;
    logic [2:0]  rx_cnt = '0;
    logic [31:0] rx_len = '0;
    logic [31:0] rx_type = '0;
    logic        rx_halted = 1'b0;
    logic [15:0] rx_buf_size = BUF_LIMIT_RESET;

    result_t     pending_results[$];
    result_t     sink_want;
    int          errors = 0;
    int          items_sent = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    varint_length_prefixed_deframer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t deframe_step(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = K_HEADER;
        if (rx_halted) begin
            r.kind = K_HALTED;
        end else if (rx_phase == PH_LENGTH || rx_phase == PH_TYPE) begin
            rx_acc = rx_acc | ({25'd0, b[6:0]} << (7 * rx_cnt));
            rx_cnt = rx_cnt + 3'd1;
            if (b[7] && rx_cnt == VARINT_MAX_BYTES) begin
                r.kind = K_ERROR;
                rx_halted = 1'b1;
            end else if (!b[7]) begin
                if (rx_phase == PH_LENGTH) begin
                    rx_len = rx_acc;
                    rx_phase = PH_TYPE;
                end else begin
                    rx_type = rx_acc;
                    rx_pos = '0;
                    if (rx_len == 32'd0) begin
                        r.kind = K_EMPTY;
                        r.last = 1'b1;
                        rx_phase = PH_PREAMBLE;
                    end else if (rx_len >= {16'd0, rx_buf_size}) begin
                        rx_phase = PH_SKIP;
                    end else begin
                        rx_phase = PH_MESSAGE;
                    end
                end
                rx_acc = '0;
                rx_cnt = '0;
            end
        end else if (rx_phase == PH_MESSAGE || rx_phase == PH_SKIP) begin
            if (rx_phase == PH_MESSAGE) begin
                r.kind = K_PAYLOAD;
                r.payload_byte = b;
            end else begin
                r.kind = K_SKIP;
            end
            rx_pos = rx_pos + 32'd1;
            if (rx_pos == rx_len) begin
                r.last = 1'b1;
                rx_pos = '0;
                rx_phase = PH_PREAMBLE;
            end
        end else if (b != PREAMBLE_BYTE) begin
            r.kind = K_ERROR;
            rx_halted = 1'b1;
        end else begin
            rx_phase = PH_LENGTH;
            rx_acc = '0;
            rx_cnt = '0;
            rx_pos = '0;
        end
        r.msg_type = rx_type;
        r.message_length = rx_len;
        return r;
    endfunction

    function automatic int idle_gap();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_type();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 3);
        if (r < 75)
            return $urandom_range(4, 16);
        if (r < 92) begin
            if (rx_buf_size <= 16'd64)
                return (rx_buf_size > 16'd2 ? rx_buf_size - 16'd2 : 16'd0) + $urandom_range(0, 4);
            return $urandom_range(0, 3);
        end
        return $urandom_range(17, 200);
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: random stalls, one long hold on request, compare each item
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d", m_tuser);
                errors++;
            end else begin
                sink_want = pending_results.pop_front();
                check_field("kind", 32'(sink_want.kind), 32'(m_tuser));
                check_field("payload_byte", 32'(sink_want.payload_byte), 32'(m_tdata[7:0]));
                check_field("msg_type", sink_want.msg_type, m_tdata[39:8]);
                check_field("message_length", sink_want.message_length, m_tdata[71:40]);
                check_field("last", 32'(sink_want.last), 32'(m_tlast));
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 3) == 0)
                stall_left = idle_gap();
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_varint_length_prefixed_deframer_core: errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 2) == 0)
            gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), deframe_step(b));
        items_sent++;
    endtask

    // width 0: pick one, mostly the shortest encoding
    task automatic send_varint(input logic [31:0] v, input int width);
        int n;
        logic [7:0] b;
        n = 1;
        while (n < VARINT_MAX_BYTES && (v >> (7 * n)) != 0)
            n++;
        if (width == 0)
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(n, VARINT_MAX_BYTES) : n;
        else if (width < n)
            width = n;
        for (int i = 0; i < width; i++) begin
            b = {1'b0, 7'(v >> (7 * i))};
            if (i < width - 1)
                b[7] = 1'b1;
            else if (i == VARINT_MAX_BYTES - 1)
                b[6:4] = 3'($urandom); // fall off the top of the 32-bit value
            send_byte(b);
        end
    endtask

    task automatic send_frame(input logic [31:0] len, input logic [31:0] msg_type,
                              input int len_width, input int type_width);
        send_byte(PREAMBLE_BYTE);
        send_varint(len, len_width);
        send_varint(msg_type, type_width);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom));
    endtask

    task automatic write_buffer_size(input logic [15:0] size);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rx_buf_size = size;
    endtask

    task automatic test_directed();
        src_gaps_on = 1'($urandom_range(0, 1));
        send_frame(32'd0, 32'hFFFF_FFFF, 1, 5);
        send_byte(PREAMBLE_BYTE);
        send_varint(32'd3, 2);
        send_varint(32'd0, 5);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_frame(32'd1, 32'd300, 1, 0);
    endtask

    task automatic test_random_traffic();
        logic [15:0] sizes [7];
        int stop_at;
        sizes = '{16'd8, 16'd65535, 16'd0, BUF_LIMIT_RESET, 16'($urandom_range(9, 64)),
                  16'd1, 16'($urandom)};
        foreach (sizes[i]) begin
            write_buffer_size(sizes[i]);
            stop_at = items_sent + ITEMS_PER_SIZE;
            while (items_sent < stop_at) begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                sink_gaps_on = ($urandom_range(0, 3) != 0);
                send_frame(random_length(), random_type(), 0, 0);
            end
        end
    endtask

    // hold the result side off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        hold_req = 1'b1;
        send_frame(32'd5, random_type(), 0, 0);
        send_frame(32'd0, random_type(), 0, 0);
        send_frame(32'd30, random_type(), 0, 0);
        sink_gaps_on = 1'b1;
        src_gaps_on = 1'b1;
    endtask

    // an error halts the parser until reset, so this runs last
    task automatic test_halt();
        halt_cause_t cause;
        cause = halt_cause_t'($urandom_range(0, 2));
        case (cause)
            HALT_BAD_PREAMBLE: begin
                send_frame(random_length(), random_type(), 0, 0);
                send_byte(8'($urandom_range(1, 255)));
            end
            HALT_LONG_LENGTH: begin
                send_byte(PREAMBLE_BYTE);
                repeat (VARINT_MAX_BYTES) send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            default: begin
                send_byte(PREAMBLE_BYTE);
                send_varint($urandom | 32'h8000_0000, VARINT_MAX_BYTES);
                repeat (VARINT_MAX_BYTES) send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
        endcase
        repeat (24) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_halt();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb_varint_length_prefixed_deframer_core: clean");
        else
            $display("tb_varint_length_prefixed_deframer_core: errors");
        $finish;
    end

endmodule
